// File: design/rws_pkg.sv
// Package for the ready and wakeup task scheduler.
// Item types, operation codes, sequencer states and defaults; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rws_pkg;

  localparam int NumTasksDefault = 16;

  typedef enum logic [2:0] {
    OP_MAKE_READY = 3'd0,
    OP_SET_WAIT   = 3'd1,
    OP_WAKE       = 3'd2,
    OP_PREEMPT    = 3'd3,
    OP_CHOOSE     = 3'd4,
    OP_NONE       = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [3:0]  task_req;
    logic [63:0] key;
    logic [63:0] wake_date;
    logic [63:0] now;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  chosen_task;
    logic        go_idle;
    logic        timer_set;
    logic [63:0] timer_date;
    logic [4:0]  woken_count;
  } out_item_t;

endpackage
`default_nettype wire

// File: design/rws_store.sv
// Per-task key and wakeup date memories, one write and one registered read each.
// Depends on rws_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rws_store
  import rws_pkg::*;
#(
  parameter int NUM_TASKS = NumTasksDefault,
  localparam int IdxW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1
) (
  input  wire logic            clk,
  input  wire logic            key_we,
  input  wire logic            date_we,
  input  wire logic [IdxW-1:0] waddr,
  input  wire logic [IdxW-1:0] raddr,
  input  wire logic [63:0]     key_wdata,
  input  wire logic [63:0]     date_wdata,
  output logic      [63:0]     key_rdata,
  output logic      [63:0]     date_rdata
);

  logic [63:0] key_mem  [NUM_TASKS];
  logic [63:0] date_mem [NUM_TASKS];

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[waddr] <= key_wdata;
    end
    if (date_we) begin
      date_mem[waddr] <= date_wdata;
    end
    key_rdata  <= key_mem[raddr];
    date_rdata <= date_mem[raddr];
  end

endmodule
`default_nettype wire

// File: design/rws_core.sv
// Sequencer, ready/waiting marks and scan datapath of the task scheduler.
// Depends on rws_pkg and rws_store.
`timescale 1ns / 1ps
`default_nettype none
module rws_core
  import rws_pkg::*;
#(
  parameter int NUM_TASKS = NumTasksDefault,
  localparam int IdxW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1,
  localparam int CntW = $clog2(NUM_TASKS + 1)
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      policy,
  input  wire logic      in_valid,
  input  wire in_item_t  in_data,
  output logic           in_stall,
  input  wire logic      out_free,
  output logic           res_valid,
  output out_item_t      res_data
);

  state_t state, state_next;

  logic [NUM_TASKS-1:0] ready_mark;
  logic [NUM_TASKS-1:0] waiting_mark;

  logic [2:0]      op_q;
  logic [IdxW-1:0] tidx_q;
  logic [63:0]     key_q;
  logic [63:0]     date_q;
  logic [63:0]     now_q;

  logic [CntW-1:0] cnt;
  logic            rd_pending;
  logic [IdxW-1:0] rd_idx;
  logic            best_found;
  logic [IdxW-1:0] best_idx;
  logic [63:0]     best_val;
  logic [4:0]      woken;

  logic [63:0] key_rdata, date_rdata;

  logic [IdxW+3:0] req_ext;
  logic [IdxW-1:0] req_idx;
  logic            req_ok;
  logic            named;
  logic            scan_hit;
  logic            preempt_win;
  logic [IdxW+3:0] best_ext;
  logic [IdxW+3:0] tidx_ext;

  assign req_ext = {{IdxW{1'b0}}, in_data.task_req};
  assign req_idx = req_ext[IdxW-1:0];
  assign req_ok  = 32'(in_data.task_req) < NUM_TASKS;
  assign named   = (in_data.operation == OP_MAKE_READY) ||
                   (in_data.operation == OP_SET_WAIT) ||
                   (in_data.operation == OP_PREEMPT);

  // Writes happen only in ST_WRITE and reads only later, so no forwarding is needed.
  rws_store #(.NUM_TASKS(NUM_TASKS)) u_store (
    .clk        (clk),
    .key_we     (state == ST_WRITE),
    .date_we    ((state == ST_WRITE) && (op_q == OP_SET_WAIT)),
    .waddr      (tidx_q),
    .raddr      (cnt[IdxW-1:0]),
    .key_wdata  (key_q),
    .date_wdata (date_q),
    .key_rdata  (key_rdata),
    .date_rdata (date_rdata)
  );

  // Whether the entry returning from memory replaces the running best.
  always_comb begin
    scan_hit = 1'b0;
    case (op_q)
      OP_SET_WAIT: begin
        scan_hit = waiting_mark[rd_idx] && (!best_found || date_rdata < best_val);
      end
      OP_PREEMPT, OP_CHOOSE: begin
        scan_hit = ready_mark[rd_idx] && (!best_found ||
                   (policy ? (key_rdata < best_val) : (key_rdata > best_val)));
      end
      default: scan_hit = 1'b0;
    endcase
  end

  assign preempt_win = best_found &&
                       (policy ? (best_val < key_q) : (best_val > key_q));
  assign best_ext    = {4'b0, best_idx};
  assign tidx_ext    = {4'b0, tidx_q};

  always_comb begin
    state_next = state;
    in_stall   = (state != ST_IDLE);
    res_valid  = 1'b0;
    res_data   = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (named && req_ok) begin
            state_next = ST_WRITE;
          end else if (in_data.operation == OP_WAKE || in_data.operation == OP_CHOOSE) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_FIN;
          end
        end
      end
      ST_WRITE: begin
        state_next = (op_q == OP_MAKE_READY) ? ST_FIN : ST_SCAN;
      end
      ST_SCAN: begin
        if (cnt == CntW'(NUM_TASKS - 1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FIN;
      end
      ST_FIN: begin
        res_valid = out_free;
        case (op_q)
          OP_SET_WAIT: begin
            res_data.timer_set  = 1'b1;
            res_data.timer_date = best_val;
          end
          OP_WAKE: res_data.woken_count = woken;
          OP_PREEMPT: begin
            res_data.chosen_task = preempt_win ? best_ext[3:0] : tidx_ext[3:0];
          end
          OP_CHOOSE: begin
            res_data.chosen_task = best_found ? best_ext[3:0] : 4'd0;
            res_data.go_idle     = !best_found;
          end
          default: res_data = '0;
        endcase
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      ready_mark   <= '0;
      waiting_mark <= '0;
      rd_pending   <= 1'b0;
      op_q         <= OP_NONE;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && in_valid) begin
        // named ops on an out-of-range task fall through as an unknown op
        op_q       <= (named && !req_ok) ? OP_NONE : in_data.operation;
        tidx_q     <= req_idx;
        key_q      <= in_data.key;
        date_q     <= in_data.wake_date;
        now_q      <= in_data.now;
        cnt        <= '0;
        best_found <= 1'b0;
        woken      <= '0;
      end
      if (state == ST_WRITE) begin
        if (op_q == OP_MAKE_READY) begin
          ready_mark[tidx_q]   <= 1'b1;
          waiting_mark[tidx_q] <= 1'b0;
        end else if (op_q == OP_SET_WAIT) begin
          ready_mark[tidx_q]   <= 1'b0;
          waiting_mark[tidx_q] <= 1'b1;
        end
      end
      if (state == ST_SCAN) begin
        rd_pending <= 1'b1;
        rd_idx     <= cnt[IdxW-1:0];
        cnt        <= cnt + 1'b1;
      end else begin
        rd_pending <= 1'b0;
      end
      if (rd_pending) begin
        if (op_q == OP_WAKE) begin
          if (waiting_mark[rd_idx] && date_rdata <= now_q) begin
            waiting_mark[rd_idx] <= 1'b0;
            ready_mark[rd_idx]   <= 1'b1;
            woken                <= woken + 1'b1;
          end
        end else if (scan_hit) begin
          best_found <= 1'b1;
          best_idx   <= rd_idx;
          best_val   <= (op_q == OP_SET_WAIT) ? date_rdata : key_rdata;
        end
      end
      if (state == ST_FIN && out_free) begin
        if (op_q == OP_PREEMPT && preempt_win) begin
          ready_mark[best_idx] <= 1'b0;
          ready_mark[tidx_q]   <= 1'b1;
          waiting_mark[tidx_q] <= 1'b0;
        end else if (op_q == OP_CHOOSE && best_found) begin
          ready_mark[best_idx] <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: design/ready_and_wakeup_task_scheduler.sv
// Top level of the ready and wakeup task scheduler: policy register and result register.
// Depends on rws_pkg and rws_core.
`timescale 1ns / 1ps
`default_nettype none
// Tracks NUM_TASKS tasks with ready and waiting marks in flip-flops and per-task
// keys and wakeup dates in two single-port-per-side memories. Make ready writes
// the key and marks only; set waiting, wake, preempt and choose scan every task
// entry through the memory read port, one entry per cycle (set waiting and preempt
// write the task's key first). One item is processed at a time; a finished result
// sits in the output register while the next item is taken. Policy must be written
// only while no item is in flight; the block itself does not enforce it.
module ready_and_wakeup_task_scheduler
  import rws_pkg::*;
#(
  parameter int NUM_TASKS = NumTasksDefault
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      cfg_we,
  input  wire logic      cfg_wdata,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  logic      policy;
  logic      out_free;
  logic      res_valid;
  out_item_t res_data;

  assign out_free = !out_valid || !out_stall;

  rws_core #(.NUM_TASKS(NUM_TASKS)) u_core (
    .clk       (clk),
    .rst       (rst),
    .policy    (policy),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      policy    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        policy <= cfg_wdata;
      end
      if (res_valid) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data <= res_data;
    end
  end

endmodule
`default_nettype wire

// File: bench/ready_and_wakeup_task_scheduler_tb.sv
// Testbench for the ready and wakeup task scheduler.
// Drives random and directed operations, predicts results and checks them in a scoreboard.
// Depends on rws_pkg and ready_and_wakeup_task_scheduler.
`timescale 1ns / 1ps
`default_nettype none

class sched_scoreboard;
  bit          policy;
  bit          ready_mark [16];
  bit          wait_mark [16];
  logic [63:0] key_mem [16];
  logic [63:0] date_mem [16];
  rws_pkg::out_item_t pending [$];
  int          errors;

  function void clear();
    policy = 0;
    foreach (ready_mark[i]) begin
      ready_mark[i] = 0;
      wait_mark[i] = 0;
      key_mem[i] = '0;
      date_mem[i] = '0;
    end
    pending.delete();
    errors = 0;
  endfunction

  function bit beats(logic [63:0] a, logic [63:0] b);
    return policy ? (a < b) : (a > b);
  endfunction

  function int best_ready();
    int b;
    b = -1;
    for (int i = 0; i < 16; i++)
      if (ready_mark[i] && (b < 0 || beats(key_mem[i], key_mem[b]))) b = i;
    return b;
  endfunction

  // Notes an accepted input and queues the scheduler's answer to it.
  function void note_input(rws_pkg::in_item_t it);
    rws_pkg::out_item_t r;
    int t, b;
    bit any;
    r = '0;
    t = int'(it.task_req);
    case (it.operation)
      rws_pkg::OP_MAKE_READY: begin
        key_mem[t] = it.key;
        ready_mark[t] = 1;
        wait_mark[t] = 0;
      end
      rws_pkg::OP_SET_WAIT: begin
        key_mem[t] = it.key;
        date_mem[t] = it.wake_date;
        wait_mark[t] = 1;
        ready_mark[t] = 0;
        any = 0;
        for (int i = 0; i < 16; i++)
          if (wait_mark[i] && (!any || date_mem[i] < r.timer_date)) begin
            r.timer_date = date_mem[i];
            any = 1;
          end
        r.timer_set = 1;
      end
      rws_pkg::OP_WAKE: begin
        for (int i = 0; i < 16; i++)
          if (wait_mark[i] && date_mem[i] <= it.now) begin
            wait_mark[i] = 0;
            ready_mark[i] = 1;
            r.woken_count++;
          end
      end
      rws_pkg::OP_PREEMPT: begin
        key_mem[t] = it.key;
        b = best_ready();
        if (b >= 0 && beats(key_mem[b], it.key)) begin
          ready_mark[b] = 0;
          ready_mark[t] = 1;
          wait_mark[t] = 0;
          r.chosen_task = 4'(b);
        end else begin
          r.chosen_task = it.task_req;
        end
      end
      rws_pkg::OP_CHOOSE: begin
        b = best_ready();
        if (b < 0) begin
          r.go_idle = 1;
        end else begin
          ready_mark[b] = 0;
          r.chosen_task = 4'(b);
        end
      end
      default: ;
    endcase
    pending.push_back(r);
  endfunction

  function void check_result(rws_pkg::out_item_t got);
    rws_pkg::out_item_t want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %h", $time, got);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got.chosen_task !== want.chosen_task) begin
      $display("%0t: chosen_task expected %0d actual %0d", $time, want.chosen_task,
               got.chosen_task);
      errors++;
    end
    if (got.go_idle !== want.go_idle) begin
      $display("%0t: go_idle expected %0d actual %0d", $time, want.go_idle, got.go_idle);
      errors++;
    end
    if (got.timer_set !== want.timer_set) begin
      $display("%0t: timer_set expected %0d actual %0d", $time, want.timer_set,
               got.timer_set);
      errors++;
    end
    if (got.timer_date !== want.timer_date) begin
      $display("%0t: timer_date expected %h actual %h", $time, want.timer_date,
               got.timer_date);
      errors++;
    end
    if (got.woken_count !== want.woken_count) begin
      $display("%0t: woken_count expected %0d actual %0d", $time, want.woken_count,
               got.woken_count);
      errors++;
    end
  endfunction
endclass

module ready_and_wakeup_task_scheduler_tb;
  import rws_pkg::*;

  logic      clk;
  logic      rst;
  logic      cfg_we;
  logic      cfg_wdata;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  sched_scoreboard sb;
  bit          sink_idle_ok;
  bit          sink_hold;
  bit          src_idle_ok;
  int          cycles;

  ready_and_wakeup_task_scheduler uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial clk = 0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: check each transfer, stall at random or for a long hold-off.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
  end

  initial begin
    int n;
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (sink_hold) begin
        out_stall = 1;
        repeat (120) @(negedge clk);
        out_stall = 0;
        sink_hold = 0;
      end else if (sink_idle_ok && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 4);
        out_stall = 1;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_stall = 0;
      end
    end
  end

  function automatic logic [63:0] rand64();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 64'($urandom_range(0, 7));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Valid stays up after a transfer until the next item, an idle burst or a drain.
  task automatic send(in_item_t it);
    if (src_idle_ok && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_data <= it;
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(it);
    @(negedge clk);
  endtask

  task automatic send_op(logic [2:0] op, logic [3:0] t, logic [63:0] k,
                         logic [63:0] d, logic [63:0] tnow);
    in_item_t it;
    it.operation = op;
    it.task_req = t;
    it.key = k;
    it.wake_date = d;
    it.now = tnow;
    send(it);
  endtask

  // Random item; ready-set reads only follow tasks whose key was written.
  task automatic send_random();
    in_item_t it;
    int r;
    it.task_req = 4'($urandom_range(0, 15));
    it.key = rand64();
    it.wake_date = rand64();
    it.now = rand64();
    r = $urandom_range(0, 99);
    if (r < 25) it.operation = OP_MAKE_READY;
    else if (r < 45) it.operation = OP_SET_WAIT;
    else if (r < 60) it.operation = OP_WAKE;
    else if (r < 75) it.operation = OP_PREEMPT;
    else if (r < 95) it.operation = OP_CHOOSE;
    else it.operation = 3'($urandom_range(5, 7));
    send(it);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic set_policy(bit p);
    cfg_wdata <= p;
    cfg_we <= 1;
    @(negedge clk);
    cfg_we <= 0;
    sb.policy = p;
  endtask

  initial begin
    sb = new();
    sb.clear();
    cycles = 0;
    rst = 1;
    cfg_we = 0;
    cfg_wdata = 0;
    in_valid = 0;
    in_data = '0;
    sink_idle_ok = 1;
    sink_hold = 0;
    src_idle_ok = 1;
    repeat (6) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // Directed: empty choose, ties, extremes, preempt both ways, wake, unknown op.
    send_op(OP_CHOOSE, 0, 0, 0, 0);
    send_op(OP_MAKE_READY, 15, '1, 0, 0);
    send_op(OP_MAKE_READY, 3, '1, 0, 0);
    send_op(OP_MAKE_READY, 7, 0, 0, 0);
    send_op(OP_PREEMPT, 1, 5, 0, 0);
    send_op(OP_PREEMPT, 2, '1, 0, 0);
    send_op(OP_CHOOSE, 0, 0, 0, 0);
    send_op(OP_SET_WAIT, 9, 4, '1, 0);
    send_op(OP_SET_WAIT, 10, 6, 64'd100, 0);
    send_op(OP_SET_WAIT, 11, 6, 0, 0);
    send_op(OP_WAKE, 0, 0, 0, 64'd99);
    send_op(OP_WAKE, 0, 0, 0, 64'd100);
    send_op(OP_WAKE, 0, 0, 0, '1);
    send_op(OP_NONE, 15, '1, '1, '1);
    send_op(3'd5, 0, 0, 0, 0);
    for (int i = 0; i < 6; i++) send_op(OP_CHOOSE, 0, 0, 0, 0);
    drain();
    set_policy(1);
    send_op(OP_MAKE_READY, 4, 64'd50, 0, 0);
    send_op(OP_MAKE_READY, 5, 64'd50, 0, 0);
    send_op(OP_PREEMPT, 6, 64'd60, 0, 0);
    send_op(OP_CHOOSE, 0, 0, 0, 0);

    // Random phases with policy flips.
    for (int ph = 0; ph < 4; ph++) begin
      for (int i = 0; i < 150; i++) send_random();
      drain();
      set_policy(ph[0]);
    end
    // Long receiver hold-off while the sender keeps offering.
    sink_hold = 1;
    for (int i = 0; i < 40; i++) send_random();
    drain();
    set_policy(1);
    // Sender pause until all results are in.
    for (int i = 0; i < 20; i++) send_random();
    drain();
    // Last part: no idling on either side.
    sink_idle_ok = 0;
    src_idle_ok = 0;
    @(negedge clk);
    for (int i = 0; i < 120; i++) send_random();
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
